// ----- src/sti_pkg.sv -----
// Package for the sorted table: widths, status and action codes, FSM states
// and the result beat type. No dependencies.
package sti_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int VALUE_BITS_DEF = 32;

    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 7;
    localparam int POS_W    = 6;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_DELETE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_SCAN,
        S_INS_PUT,
        S_DEL_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        t_status              status;
        logic [TOTAL_W-1:0]   entry_total;
        logic [POS_W-1:0]     position;
    } t_result;

endpackage

// ----- src/sti_if.sv -----
// Valid/ready channel interfaces for the sorted table: request and response.
// Depends on sti_pkg for the response field widths.
interface sti_req_if #(
    parameter int VALUE_BITS = sti_pkg::VALUE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface sti_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [sti_pkg::STATUS_W-1:0]  status;
    logic [sti_pkg::TOTAL_W-1:0]   entry_total;
    logic [sti_pkg::POS_W-1:0]     position;

    modport source (output valid, output status, output entry_total, output position,
                    input ready);
    modport sink   (input valid, input status, input entry_total, input position,
                    output ready);
endinterface

// ----- src/sorted_table_insert_delete.sv -----
// Top level of the sorted table: table memory, scan/shift sequencer, count.
// Depends on sti_pkg, sti_req_if, sti_rsp_if and sti_out_stage.
//
//   Channel   Direction   Beat payload                      Handshake
//   i_req     in          action, value                     valid/ready
//   o_rsp     out         status, entry_total, position     valid/ready
//
// Sequencing: one item at a time. An insert runs through accept, a scan of
// the stored entries from the top, the final write and the hand-off; a delete
// runs through accept, a scan from the bottom and the hand-off. The scan is a
// read, compare and write-back loop over the table memory, which moves one
// entry per cycle.
// Reset clears only the entry count and control; the table needs no clearing
// pass because only entries below the count are ever read.
// A stalled o_rsp holds the finished beat in the output register; the next
// request is still accepted and runs until its own result is ready to load.
module sorted_table_insert_delete #(
    parameter int CAPACITY   = sti_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = sti_pkg::VALUE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sti_req_if.sink     i_req,
    sti_rsp_if.source   o_rsp
);
    import sti_pkg::*;

    // Address width of the table and width of a count that can hold CAPACITY.
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    // Table memory: one write port and one registered read port.
    logic signed [VALUE_BITS-1:0] r_mem [CAPACITY];
    logic signed [VALUE_BITS-1:0] r_rdata;
    logic                         mem_we;
    logic                         mem_re;
    logic [AW-1:0]                mem_waddr;
    logic [AW-1:0]                mem_raddr;
    logic signed [VALUE_BITS-1:0] mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // Sequencer state. r_idx is the table index whose data arrives in r_rdata
    // during a scan state.
    t_state                       r_state, n_state;
    logic [CW-1:0]                r_count, n_count;
    logic signed [VALUE_BITS-1:0] r_key,   n_key;
    logic [AW-1:0]                r_idx,   n_idx;
    logic [AW-1:0]                r_pos,   n_pos;
    logic                         r_found, n_found;
    t_status                      r_status, n_status;

    logic    accept;
    logic    out_free;
    logic    is_last;
    logic    key_less;
    logic    key_match;
    t_result result;

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;

    // Insert scans downward while the stored entry is strictly greater, so an
    // equal entry stops the scan and the new value lands after it.
    assign key_less  = (r_rdata > r_key);
    assign key_match = (r_rdata == r_key);
    assign is_last   = (CW'(r_idx) == (r_count - CW'(1)));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req.action == ACT_INSERT) begin
                        if (r_count == CAP_CNT) begin
                            n_state = S_DONE;
                        end else if (r_count == '0) begin
                            n_state = S_INS_PUT;
                        end else begin
                            n_state = S_INS_SCAN;
                        end
                    end else begin
                        n_state = (r_count == '0) ? S_DONE : S_DEL_SCAN;
                    end
                end
            end
            S_INS_SCAN: begin
                if (!key_less) begin
                    n_state = S_DONE;
                end else if (r_idx == '0) begin
                    n_state = S_INS_PUT;
                end
            end
            S_INS_PUT: begin
                n_state = S_DONE;
            end
            S_DEL_SCAN: begin
                if (is_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Memory controls and datapath register updates.
    always_comb begin
        n_count   = r_count;
        n_key     = r_key;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_found   = r_found;
        n_status  = r_status;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = r_idx;
        mem_raddr = r_idx;
        mem_wdata = r_rdata;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_key    = i_req.value;
                    n_found  = 1'b0;
                    n_pos    = '0;
                    n_status = ST_OK;
                    if (i_req.action == ACT_INSERT) begin
                        if (r_count == CAP_CNT) begin
                            n_status = ST_FULL;
                        end else if (r_count != '0) begin
                            // Start from the topmost stored entry.
                            mem_re    = 1'b1;
                            mem_raddr = AW'(r_count - CW'(1));
                            n_idx     = AW'(r_count - CW'(1));
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            mem_re    = 1'b1;
                            mem_raddr = '0;
                            n_idx     = '0;
                        end
                    end
                end
            end
            S_INS_SCAN: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx + AW'(1);
                if (key_less) begin
                    // Move the larger entry up one slot and keep looking down.
                    mem_wdata = r_rdata;
                    if (r_idx != '0) begin
                        mem_re    = 1'b1;
                        mem_raddr = r_idx - AW'(1);
                        n_idx     = r_idx - AW'(1);
                    end else begin
                        n_pos = '0;
                    end
                end else begin
                    mem_wdata = r_key;
                    n_pos     = r_idx + AW'(1);
                    n_count   = r_count + CW'(1);
                end
            end
            S_INS_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos;
                mem_wdata = r_key;
                n_count   = r_count + CW'(1);
            end
            S_DEL_SCAN: begin
                if (r_found) begin
                    // Past the removed entry: pull each entry down one slot.
                    mem_we    = 1'b1;
                    mem_waddr = r_idx - AW'(1);
                    mem_wdata = r_rdata;
                end else if (key_match) begin
                    n_found = 1'b1;
                    n_pos   = r_idx;
                end
                if (!is_last) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_idx + AW'(1);
                    n_idx     = r_idx + AW'(1);
                end else if (r_found || key_match) begin
                    n_count = r_count - CW'(1);
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_found  <= n_found;
        r_status <= n_status;
    end

    assign result.status      = r_status;
    assign result.entry_total = TOTAL_W'(r_count);
    assign result.position    = (r_status == ST_OK) ? POS_W'(r_pos) : '0;

    sti_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (r_state == S_DONE),
        .i_result (result),
        .o_free   (out_free),
        .o_rsp    (o_rsp)
    );

endmodule

// ----- src/sti_out_stage.sv -----
// Output register for result beats of the sorted table.
// Depends on sti_pkg (t_result) and sti_rsp_if.
module sti_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  sti_pkg::t_result i_result,
    output logic             o_free,
    sti_rsp_if.source        o_rsp
);
    import sti_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load && o_free) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_res <= i_result;
        end
    end

    assign o_rsp.valid       = r_valid;
    assign o_rsp.status      = r_res.status;
    assign o_rsp.entry_total = r_res.entry_total;
    assign o_rsp.position    = r_res.position;

endmodule

// ----- src/sti_checker.sv -----
// Port-level assertions for the sorted table and the bind that attaches them.
// Depends on sti_pkg and on sorted_table_insert_delete.
module sti_checker #(
    parameter int CAPACITY = sti_pkg::CAPACITY_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_rsp_valid,
    input logic                         i_rsp_ready,
    input logic [sti_pkg::STATUS_W-1:0] i_rsp_status,
    input logic [sti_pkg::TOTAL_W-1:0]  i_rsp_entry_total,
    input logic [sti_pkg::POS_W-1:0]    i_rsp_position
);
    import sti_pkg::*;

    localparam logic [TOTAL_W-1:0] FULL_TOTAL = TOTAL_W'(CAPACITY);

    // A beat that is not taken stays on offer.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response beat dropped while stalled");

    // Failed operations report position zero.
    a_fail_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status != ST_OK) |-> i_rsp_position == '0)
        else $error("nonzero position on a failed operation");

    // A full report only comes from a full table.
    a_full_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status == ST_FULL) |-> i_rsp_entry_total == FULL_TOTAL)
        else $error("full status with table not full");

    // An empty report only comes from an empty table.
    a_empty_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status == ST_EMPTY) |-> i_rsp_entry_total == '0)
        else $error("empty status with entries present");

    // No beat is offered right after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid right after reset");

endmodule

bind sorted_table_insert_delete sti_checker #(
    .CAPACITY (CAPACITY)
) u_sti_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_status      (o_rsp.status),
    .i_rsp_entry_total (o_rsp.entry_total),
    .i_rsp_position    (o_rsp.position)
);
